FILE: src/iale_pkg.sv
package iale_pkg;

    typedef enum logic [3:0] {
        OP_PUSH    = 4'd0,
        OP_POP     = 4'd1,
        OP_READ    = 4'd2,
        OP_WRITE   = 4'd3,
        OP_INSERT  = 4'd4,
        OP_ERASE   = 4'd5,
        OP_FIND    = 4'd6,
        OP_PUSHN   = 4'd7,
        OP_POPN    = 4'd8,
        OP_INSERTN = 4'd9,
        OP_ERASEN  = 4'd10,
        OP_RESIZE  = 4'd11
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int OP_BITS     = 4;
    localparam int FIELD_BITS  = 7;
    localparam int VALUE_BITS  = 32;
    localparam int FPOS_BITS   = 6;

    // memory operation issued by the controller for one step
    typedef enum logic [2:0] {
        MC_NONE,
        MC_READ,   // read addr into the read register
        MC_MOVE,   // write the read register at waddr
        MC_FILL,   // write fill value at waddr
        MC_ZERO    // write zero at waddr
    } t_mcmd;

    typedef struct packed {
        t_mcmd mcmd;
        logic  cmp;   // compare read data with search value
    } t_dp_cmd;

endpackage

FILE: src/iale_datapath.sv
module iale_datapath #(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 32,
    parameter int AW        = 6
) (
    input  logic                   i_clk,
    input  iale_pkg::t_dp_cmd      i_cmd,
    input  logic [AW-1:0]          i_raddr,
    input  logic [AW-1:0]          i_waddr,
    input  logic [ELEM_BITS-1:0]   i_value,
    output logic [ELEM_BITS-1:0]   o_rdata,
    output logic                   o_match
);
    import iale_pkg::*;

    logic [ELEM_BITS-1:0] mem [DEPTH];
    logic [ELEM_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mcmd == MC_READ) begin
            r_rdata <= mem[i_raddr];
        end
        unique case (i_cmd.mcmd)
            MC_MOVE: mem[i_waddr] <= r_rdata;
            MC_FILL: mem[i_waddr] <= i_value;
            MC_ZERO: mem[i_waddr] <= '0;
            default: ;
        endcase
    end

    assign o_rdata = r_rdata;
    assign o_match = i_cmd.cmp && (r_rdata == i_value);

endmodule

FILE: src/iale_ctrl.sv
module iale_ctrl #(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 32,
    parameter int AW        = 6,
    parameter int CW        = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [iale_pkg::OP_BITS-1:0]  i_req_type,
    input  logic [iale_pkg::FIELD_BITS-1:0] i_position,
    input  logic [iale_pkg::FIELD_BITS-1:0] i_amount,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic                          o_rd,
    output logic                          o_found,
    output logic [iale_pkg::FPOS_BITS-1:0] o_found_position,
    output logic [iale_pkg::FIELD_BITS-1:0] o_length,
    output iale_pkg::t_dp_cmd             o_cmd,
    output logic [AW-1:0]                 o_raddr,
    output logic [AW-1:0]                 o_waddr,
    input  logic                          i_match
);
    import iale_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_RD, S_MV, S_FILL, S_FIND, S_OUT
    } t_state;

    t_state         r_state;
    logic [3:0]     r_op;
    logic [CW-1:0]  r_pos, r_amt, r_cnt;
    logic [CW:0]    r_src, r_dst, r_lim;   // src/dst walk, lim = end
    logic           r_down;                // move direction: 1 = toward top
    logic [CW-1:0]  r_fill_ptr, r_fill_end;
    logic           r_zero;
    logic [1:0]     r_status;
    logic           r_rd, r_found;
    logic [CW-1:0]  r_fpos, r_fidx;
    logic           r_fpend;

    localparam logic [CW:0] DEPTH_W = (CW+1)'(DEPTH);

    logic [CW:0] w_pos, w_amt, w_cnt, w_sum, w_n;
    assign w_pos = {1'b0, r_pos};
    assign w_amt = {1'b0, r_amt};
    assign w_cnt = {1'b0, r_cnt};
    assign w_sum = w_cnt + w_amt;
    // shift distance for insert/erase and their n variants: 1 or the amount
    assign w_n   = (r_op == OP_INSERT || r_op == OP_ERASE) ? (CW+1)'(1) : w_amt;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_rd = r_rd;
    assign o_found = r_found;
    assign o_found_position = FPOS_BITS'(r_fpos);
    assign o_length = FIELD_BITS'(r_cnt);

    always_comb begin
        o_cmd.mcmd = MC_NONE;
        o_cmd.cmp  = 1'b0;
        o_raddr    = r_src[AW-1:0];
        o_waddr    = r_dst[AW-1:0];
        unique case (r_state)
            S_RD:   o_cmd.mcmd = MC_READ;
            S_MV:   o_cmd.mcmd = MC_MOVE;
            S_FILL: begin
                o_cmd.mcmd = r_zero ? MC_ZERO : MC_FILL;
                o_waddr    = r_fill_ptr[AW-1:0];
            end
            S_FIND: begin
                o_cmd.mcmd = MC_READ;
                o_cmd.cmp  = r_fpend;
                o_raddr    = r_fidx[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op    <= i_req_type;
                    r_pos   <= CW'(i_position);
                    r_amt   <= CW'(i_amount);
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_status <= ST_OK;
                    r_rd     <= 1'b0;
                    r_found  <= 1'b0;
                    r_fpos   <= '0;
                    r_zero   <= 1'b0;
                    r_state  <= S_OUT;
                    unique case (r_op)
                        OP_PUSH: if (w_cnt >= DEPTH_W) r_status <= ST_FULL;
                        else begin
                            r_fill_ptr <= r_cnt; r_fill_end <= CW'(w_cnt + 1'b1);
                            r_cnt <= CW'(w_cnt + 1'b1); r_state <= S_FILL;
                        end
                        OP_POP: if (r_cnt != 0) r_cnt <= r_cnt - 1'b1;
                        OP_READ: if (w_pos >= w_cnt) r_status <= ST_RANGE;
                        else begin
                            r_src <= w_pos; r_rd <= 1'b1; r_lim <= '0;
                            r_down <= 1'b0; r_state <= S_RD;
                        end
                        OP_WRITE: if (w_pos >= w_cnt) r_status <= ST_RANGE;
                        else begin
                            r_fill_ptr <= r_pos; r_fill_end <= CW'(w_pos + 1'b1);
                            r_state <= S_FILL;
                        end
                        OP_INSERT, OP_INSERTN: begin
                            if (w_pos > w_cnt) r_status <= ST_RANGE;
                            else if (w_cnt + w_n > DEPTH_W) r_status <= ST_FULL;
                            else begin
                                // move [pos,cnt) up by n, from the top down
                                r_down <= 1'b1;
                                r_src <= w_cnt - 1'b1; r_dst <= w_cnt + w_n - 1'b1;
                                r_lim <= w_pos;
                                r_fill_ptr <= r_pos; r_fill_end <= CW'(w_pos + w_n);
                                r_cnt <= CW'(w_cnt + w_n);
                                r_state <= (w_cnt > w_pos) ? S_RD :
                                           ((w_n != 0) ? S_FILL : S_OUT);
                            end
                        end
                        OP_ERASE, OP_ERASEN: begin
                            if (w_pos >= w_cnt) r_status <= ST_RANGE;
                            else if (w_pos + w_n >= w_cnt) r_cnt <= r_pos;
                            else begin
                                r_down <= 1'b0;
                                r_src <= w_pos + w_n; r_dst <= w_pos; r_lim <= w_cnt;
                                r_cnt <= CW'(w_cnt - w_n);
                                r_state <= (w_n != 0) ? S_RD : S_OUT;
                            end
                        end
                        OP_FIND: if (r_cnt != 0) begin
                            r_fidx <= '0; r_fpend <= 1'b0; r_state <= S_FIND;
                        end
                        OP_PUSHN: if (w_sum > DEPTH_W) r_status <= ST_FULL;
                        else begin
                            r_fill_ptr <= r_cnt; r_fill_end <= CW'(w_sum);
                            r_cnt <= CW'(w_sum);
                            if (r_amt != 0) r_state <= S_FILL;
                        end
                        OP_POPN: r_cnt <= (w_amt >= w_cnt) ? '0 : CW'(w_cnt - w_amt);
                        OP_RESIZE: if (w_amt > DEPTH_W) r_status <= ST_FULL;
                        else begin
                            r_fill_ptr <= r_cnt; r_fill_end <= r_amt;
                            r_zero <= 1'b1; r_cnt <= r_amt;
                            if (w_amt > w_cnt) r_state <= S_FILL;
                        end
                        default: ;
                    endcase
                end
                S_RD: r_state <= (r_lim == '0 && !r_down && r_rd) ? S_OUT : S_MV;
                S_MV: begin
                    if (r_down) begin
                        r_src <= r_src - 1'b1; r_dst <= r_dst - 1'b1;
                        if (r_src == r_lim)
                            r_state <= (r_fill_ptr != r_fill_end) ? S_FILL : S_OUT;
                        else r_state <= S_RD;
                    end else begin
                        r_src <= r_src + 1'b1; r_dst <= r_dst + 1'b1;
                        r_state <= (r_src + 1'b1 == r_lim) ? S_OUT : S_RD;
                    end
                end
                S_FILL: begin
                    r_fill_ptr <= r_fill_ptr + 1'b1;
                    if (r_fill_ptr + 1'b1 == r_fill_end) r_state <= S_OUT;
                end
                S_FIND: begin
                    // compare of previous read lands while next read issues
                    if (r_fpend && i_match) begin
                        r_found <= 1'b1; r_fpos <= r_fidx - 1'b1; r_state <= S_OUT;
                    end else if (r_fidx == r_cnt) begin
                        r_state <= S_OUT;
                    end else begin
                        r_fidx <= r_fidx + 1'b1; r_fpend <= 1'b1;
                    end
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/indexed_array_list_engine_core.sv
// list engine: each request beat yields one result beat. pop, popn and resize-shrink
// only change the length; push, write and read make one memory access; insert/erase
// walk the moved elements with a read then a write each (one memory command per
// step), then insert fills its copies; pushn, insertn fill and resize growth write
// one element per cycle; find reads one element per cycle until the first
// match. status 1 is an index at or past the length (past it for insert), status
// 2 a request that would exceed DEPTH; on an error the list is unchanged.
module indexed_array_list_engine_core #(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [iale_pkg::OP_BITS-1:0]         i_req_type,
    input  logic [iale_pkg::FIELD_BITS-1:0]      i_position,
    input  logic signed [iale_pkg::VALUE_BITS-1:0] i_item_value,
    input  logic [iale_pkg::FIELD_BITS-1:0]      i_amount,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [1:0]                           o_status,
    output logic signed [iale_pkg::VALUE_BITS-1:0] o_read_value,
    output logic                                 o_found,
    output logic [iale_pkg::FPOS_BITS-1:0]       o_found_position,
    output logic [iale_pkg::FIELD_BITS-1:0]      o_length
);
    import iale_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // count width covers both the list length and the full request fields
    localparam int CW = ($clog2(DEPTH + 1) > FIELD_BITS) ? $clog2(DEPTH + 1) : FIELD_BITS;

    t_dp_cmd              w_cmd;
    logic [AW-1:0]        w_raddr, w_waddr;
    logic [ELEM_BITS-1:0] w_rdata, r_value;
    logic                 w_match, w_rd;

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) r_value <= ELEM_BITS'($unsigned(i_item_value));
    end

    iale_ctrl #(.DEPTH(DEPTH), .ELEM_BITS(ELEM_BITS), .AW(AW), .CW(CW)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req_type, .i_position, .i_amount,
        .o_valid, .i_stall, .o_status, .o_rd(w_rd), .o_found, .o_found_position,
        .o_length, .o_cmd(w_cmd), .o_raddr(w_raddr), .o_waddr(w_waddr),
        .i_match(w_match)
    );

    iale_datapath #(.DEPTH(DEPTH), .ELEM_BITS(ELEM_BITS), .AW(AW)) u_dp (
        .i_clk, .i_cmd(w_cmd), .i_raddr(w_raddr), .i_waddr(w_waddr),
        .i_value(r_value), .o_rdata(w_rdata), .o_match(w_match)
    );

    assign o_read_value = w_rd ? VALUE_BITS'(signed'(w_rdata)) : '0;

endmodule

FILE: src/iale_checker.sv
module iale_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic       o_found,
    input logic [6:0] o_length
);
    import iale_pkg::*;

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_RANGE || o_status == ST_FULL))
        else $error("bad status");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == ST_OK)) else $error("found with error");
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accepting while result pending");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("second beat taken");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_length)))
        else $error("result dropped");
endmodule

bind indexed_array_list_engine_core iale_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_status, .o_found,
    .o_length
);

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import iale_pkg::*;

    localparam int LIST_DEPTH = 64;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic        found;
        logic [5:0]  found_position;
        logic [6:0]  length;
    } t_answer;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [3:0]        i_req_type = '0;
    logic [6:0]        i_position = '0;
    logic signed [31:0] i_item_value = '0;
    logic [6:0]        i_amount = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_status;
    logic signed [31:0] o_read_value;
    logic              o_found;
    logic [5:0]        o_found_position;
    logic [6:0]        o_length;

    logic [31:0] shadow_list [LIST_DEPTH];
    int          shadow_len;
    t_answer     pending_answers [$];
    int          mismatch_count = 0;
    bit          gaps_on = 1'b1;

    indexed_array_list_engine_core #(.DEPTH(LIST_DEPTH), .ELEM_BITS(32)) i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req_type, .i_position,
        .i_item_value, .i_amount, .o_valid, .i_stall, .o_status,
        .o_read_value, .o_found, .o_found_position, .o_length
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // list behavior: returns the answer and updates the shadow list
    function automatic t_answer apply_request(logic [3:0] op, int pos, logic [31:0] val,
                                              int amt);
        t_answer a;
        int i;
        a = '0;
        case (op)
            OP_PUSH: begin
                if (shadow_len >= LIST_DEPTH) a.status = ST_FULL;
                else begin
                    shadow_list[shadow_len] = val;
                    shadow_len++;
                end
            end
            OP_POP: if (shadow_len > 0) shadow_len--;
            OP_READ: begin
                if (pos >= shadow_len) a.status = ST_RANGE;
                else a.read_value = shadow_list[pos];
            end
            OP_WRITE: begin
                if (pos >= shadow_len) a.status = ST_RANGE;
                else shadow_list[pos] = val;
            end
            OP_INSERT, OP_INSERTN: begin
                if (op == OP_INSERT) amt = 1;
                if (pos > shadow_len) a.status = ST_RANGE;
                else if (shadow_len + amt > LIST_DEPTH) a.status = ST_FULL;
                else begin
                    for (i = shadow_len - 1; i >= pos; i--) shadow_list[i + amt] = shadow_list[i];
                    for (i = 0; i < amt; i++) shadow_list[pos + i] = val;
                    shadow_len += amt;
                end
            end
            OP_ERASE, OP_ERASEN: begin
                if (op == OP_ERASE) amt = 1;
                if (pos >= shadow_len) a.status = ST_RANGE;
                else if (pos + amt >= shadow_len) shadow_len = pos;
                else begin
                    for (i = pos; i + amt < shadow_len; i++) shadow_list[i] = shadow_list[i + amt];
                    shadow_len -= amt;
                end
            end
            OP_FIND: begin
                for (i = 0; i < shadow_len; i++) begin
                    if (shadow_list[i] == val) begin
                        a.found = 1'b1;
                        a.found_position = i[5:0];
                        break;
                    end
                end
            end
            OP_PUSHN: begin
                if (shadow_len + amt > LIST_DEPTH) a.status = ST_FULL;
                else begin
                    for (i = 0; i < amt; i++) shadow_list[shadow_len + i] = val;
                    shadow_len += amt;
                end
            end
            OP_POPN: shadow_len = (amt >= shadow_len) ? 0 : shadow_len - amt;
            OP_RESIZE: begin
                if (amt > LIST_DEPTH) a.status = ST_FULL;
                else begin
                    for (i = shadow_len; i < amt; i++) shadow_list[i] = '0;
                    shadow_len = amt;
                end
            end
            default: ;
        endcase
        a.length = shadow_len[6:0];
        return a;
    endfunction

    task automatic send_request(logic [3:0] op, logic [6:0] pos, logic [31:0] val,
                                logic [6:0] amt);
        t_answer ans;
        while (gaps_on && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= op;
        i_position <= pos;
        i_item_value <= val;
        i_amount <= amt;
        do @(posedge i_clk); while (o_stall);
        ans = apply_request(op, int'(pos), val, int'(amt));
        pending_answers.insert(pending_answers.size(), ans);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result beat at %0t", $realtime);
            end else begin
                t_answer want;
                want = pending_answers.pop_front();
                if (o_status !== want.status || o_read_value !== want.read_value
                    || o_found !== want.found || o_found_position !== want.found_position
                    || o_length !== want.length) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: exp st=%0d rd=%h f=%0d fp=%0d len=%0d,",
                                  " got st=%0d rd=%h f=%0d fp=%0d len=%0d"},
                                 want.status, want.read_value, want.found, want.found_position,
                                 want.length, o_status, o_read_value, o_found,
                                 o_found_position, o_length);
                end
            end
        end
        i_stall <= gaps_on && ($urandom_range(99) < 14);
    end

    task automatic test_edge_cases();
        send_request(OP_POP, 0, 0, 0);
        send_request(OP_READ, 0, 0, 0);
        send_request(OP_ERASEN, 0, 0, 0);
        send_request(OP_PUSH, 0, 32'h8000_0000, 0);
        send_request(OP_PUSH, 0, 32'h7fff_ffff, 0);
        send_request(OP_INSERT, 1, 32'hffff_ffff, 0);
        send_request(OP_INSERT, 5, 1, 0);
        send_request(OP_READ, 1, 0, 0);
        send_request(OP_WRITE, 0, 32'h1234_5678, 0);
        send_request(OP_WRITE, 127, 1, 0);
        send_request(OP_FIND, 0, 32'h7fff_ffff, 0);
        send_request(OP_FIND, 0, 32'h5555_5555, 0);
        send_request(OP_ERASE, 0, 0, 0);
        send_request(OP_PUSHN, 0, 32'haaaa_aaaa, 62);
        send_request(OP_PUSH, 0, 9, 0);
        send_request(OP_PUSH, 0, 9, 0);
        send_request(OP_INSERT, 0, 3, 0);
        send_request(OP_INSERTN, 70, 3, 1);
        send_request(OP_PUSHN, 0, 3, 1);
        send_request(OP_ERASEN, 10, 0, 5);
        send_request(OP_RESIZE, 0, 0, 65);
        send_request(OP_RESIZE, 0, 0, 64);
        send_request(OP_POPN, 0, 0, 127);
        send_request(4'd13, 127, 32'hffff_ffff, 127);
        send_request(OP_RESIZE, 0, 0, 3);
    endtask

    task automatic test_random_traffic(int count);
        int n;
        logic [3:0] op;
        logic [6:0] pos, amt;
        logic [31:0] val;
        for (n = 0; n < count; n++) begin
            op = 4'($urandom_range(0, 11));
            if ($urandom_range(99) < 3) op = 4'($urandom_range(12, 15));
            // positions mostly near the live region, a few anywhere
            if ($urandom_range(99) < 8) pos = 7'($urandom);
            else pos = 7'($urandom_range(0, shadow_len + 1));
            if ($urandom_range(99) < 5) amt = 7'($urandom);
            else if ($urandom_range(99) < 15) amt = 7'($urandom_range(0, 64));
            else amt = 7'($urandom_range(0, 8));
            // small value set so find hits often
            if ($urandom_range(99) < 60) val = $urandom_range(0, 5) - 2;
            else val = $urandom;
            if (shadow_len > 56 && (op == OP_PUSHN || op == OP_INSERTN) && $urandom_range(1))
                op = OP_POPN;
            send_request(op, pos, val, amt);
        end
    endtask

    initial begin
        int wait_cycles;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_cases();
        test_random_traffic(700);
        gaps_on = 1'b0;
        test_random_traffic(200);
        gaps_on = 1'b1;
        test_random_traffic(300);
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_answers.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("indexed_array_list_engine_core: match");
        else
            $display("indexed_array_list_engine_core: mismatch");
        $finish;
    end

    initial begin
        #50ms;
        $display("indexed_array_list_engine_core: mismatch");
        $finish;
    end
endmodule
